FILE: sv/stream_suffix_dictionary_match_defines.svh
// ---------------------------------------------------------------------------
// stream_suffix_dictionary_match_defines
// Assertion macros for the suffix dictionary matcher.
// ---------------------------------------------------------------------------
`ifndef STREAM_SUFFIX_DICTIONARY_MATCH_DEFINES_SVH
`define STREAM_SUFFIX_DICTIONARY_MATCH_DEFINES_SVH
// implication checked at every clock edge outside reset
`define SSDM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define SSDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: sv/ssdm_pkg.sv
// ---------------------------------------------------------------------------
// ssdm_pkg
// Shared types and constants of the suffix dictionary matcher.
// ---------------------------------------------------------------------------
`default_nettype none
package ssdm_pkg;
   localparam int NODE_CAPACITY_DEF = 4096;
   localparam int MAX_WORD_LEN_DEF  = 64;
   localparam int ALPHABET_SIZE_DEF = 26;
   localparam int LETTER_W = 5;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LD_READ, S_LD_WAIT, S_LD_DO,
      S_Q_PUSH, S_Q_HIST, S_Q_READ, S_Q_WAIT, S_Q_STEP, S_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic ld_read;
      logic ld_commit;
      logic q_push;
      logic q_read;
      logic q_step;
      logic out_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;
      logic is_query;
      logic q_done;
   } sts_type;
endpackage
`default_nettype wire

FILE: sv/ssdm_ctrl.sv
// ---------------------------------------------------------------------------
// ssdm_ctrl
// Sequencer: clear sweep, load and query walk steps, result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none
module ssdm_ctrl
   import ssdm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire logic    out_busy,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.capture = 1'b1;
               state_in = S_LD_READ;
            end
         end
         S_LD_READ: begin
            if (sts.is_query) begin
               state_in = S_Q_PUSH;
            end else begin
               cmd.ld_read = 1'b1;
               state_in = S_LD_WAIT;
            end
         end
         S_LD_WAIT: state_in = S_LD_DO;
         S_LD_DO: begin
            cmd.ld_commit = 1'b1;
            state_in = S_OUT;
         end
         S_Q_PUSH: begin
            cmd.q_push = 1'b1;
            state_in = S_Q_HIST;
         end
         // history letter at the walk position lands in its read register
         S_Q_HIST: state_in = S_Q_READ;
         S_Q_READ: begin
            if (sts.q_done) begin
               state_in = S_OUT;
            end else begin
               cmd.q_read = 1'b1;
               state_in = S_Q_WAIT;
            end
         end
         S_Q_WAIT: state_in = S_Q_STEP;
         S_Q_STEP: begin
            cmd.q_step = 1'b1;
            state_in = S_Q_HIST;
         end
         S_OUT: begin
            if (!out_busy) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end
endmodule
`default_nettype wire

FILE: sv/ssdm_datapath.sv
// ---------------------------------------------------------------------------
// ssdm_datapath
// Node table, end marks, history ring, load cursor and walk registers.
// ---------------------------------------------------------------------------
`default_nettype none
module ssdm_datapath
   import ssdm_pkg::*;
#(
   parameter int NODE_CAPACITY = NODE_CAPACITY_DEF,
   parameter int MAX_WORD_LEN  = MAX_WORD_LEN_DEF,
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output sts_type                  sts,
   input  wire logic                in_command,
   input  wire logic [LETTER_W-1:0] in_letter,
   input  wire logic                in_word_end,
   output logic                     res_match,
   output logic [STATUS_W-1:0]      res_status
);
   localparam int NODE_W  = $clog2(NODE_CAPACITY);
   localparam int CNT_W   = $clog2(NODE_CAPACITY + 1);
   localparam int ALPHA_W = $clog2(ALPHABET_SIZE);
   localparam int LINKS   = NODE_CAPACITY * ALPHABET_SIZE;
   localparam int LINK_W  = $clog2(LINKS);
   localparam int HIST_W  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
   localparam int LEN_W   = $clog2(MAX_WORD_LEN + 1);
   localparam int SWEEP_W = $clog2(LINKS + 1);

   logic [NODE_W-1:0]   link_mem [LINKS];
   logic                mark_mem [NODE_CAPACITY];
   logic [LETTER_W-1:0] hist_mem [MAX_WORD_LEN];

   logic [SWEEP_W-1:0]  sweep_ff;
   logic                cmd_ff;
   logic [LETTER_W-1:0] letter_ff;
   logic                end_ff;
   logic [CNT_W-1:0]    used_ff;
   logic [NODE_W-1:0]   cursor_ff;
   logic [LEN_W-1:0]    length_ff;
   logic [STATUS_W-1:0] fail_ff;
   logic [HIST_W-1:0]   head_ff;
   logic [LEN_W-1:0]    fill_ff;
   logic [NODE_W-1:0]   node_ff;
   logic [LEN_W-1:0]    idx_ff;
   logic [HIST_W-1:0]   pos_ff;
   logic                done_ff;
   logic                match_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [NODE_W-1:0]   rd_link_ff;
   logic                rd_mark_ff;
   logic [LETTER_W-1:0] rd_hist_ff;
   logic                ld_ok_letter;

   logic [LINK_W-1:0]   ld_addr, q_addr, rd_addr;
   logic [NODE_W-1:0]   cand;
   logic                need_new, full, long_word, ld_active;

   // node * ALPHABET_SIZE: a multiplier on narrow operands for each of the load and query addresses
   assign ld_addr = LINK_W'(cursor_ff * ALPHABET_SIZE) + LINK_W'(letter_ff);
   assign q_addr  = LINK_W'(node_ff * ALPHABET_SIZE) + LINK_W'(rd_hist_ff);
   assign rd_addr = cmd.ld_read ? ld_addr : q_addr;

   assign sts.clear_done = (sweep_ff == SWEEP_W'(LINKS - 1));
   assign sts.is_query   = (cmd_ff == CMD_QUERY);
   assign sts.q_done     = done_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         link_mem[LINK_W'(sweep_ff)] <= '0;
         if (sweep_ff < SWEEP_W'(NODE_CAPACITY))
            mark_mem[NODE_W'(sweep_ff)] <= 1'b0;
      end
      if (cmd.ld_read || cmd.q_read) rd_link_ff <= link_mem[rd_addr];
      rd_mark_ff <= mark_mem[rd_link_ff];
      rd_hist_ff <= hist_mem[pos_ff];
      if (cmd.q_push) hist_mem[head_ff] <= letter_ff;
      if (cmd.ld_commit && ld_active && !long_word && need_new && !full)
         link_mem[ld_addr] <= NODE_W'(used_ff);
      if (cmd.ld_commit && end_ff && fail_ff == ST_OK && !(ld_active && (long_word ||
          (need_new && full))) && (length_ff != '0 || (ld_active && !long_word)))
         mark_mem[ld_active ? cand : cursor_ff] <= 1'b1;
   end

   assign ld_ok_letter = (letter_ff < LETTER_W'(ALPHABET_SIZE));
   assign ld_active = (fail_ff == ST_OK) && ld_ok_letter;
   assign long_word = (length_ff >= LEN_W'(MAX_WORD_LEN));
   assign need_new  = (rd_link_ff == '0);
   assign full      = (used_ff >= CNT_W'(NODE_CAPACITY));
   assign cand      = need_new ? NODE_W'(used_ff) : rd_link_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff  <= '0;
         used_ff   <= CNT_W'(1);
         cursor_ff <= '0;
         length_ff <= '0;
         fail_ff   <= ST_OK;
         head_ff   <= '0;
         fill_ff   <= '0;
         done_ff   <= 1'b0;
         cmd_ff    <= CMD_LOAD;
      end else begin
         if (cmd.clear_step) sweep_ff <= sweep_ff + 1'b1;
         if (cmd.capture) begin
            cmd_ff    <= in_command;
            letter_ff <= in_letter;
            end_ff    <= in_word_end;
         end
         if (cmd.ld_commit) begin
            match_ff <= 1'b0;
            if (!ld_active)            status_ff <= fail_ff;
            else if (long_word)        status_ff <= ST_TOO_LONG;
            else if (need_new && full) status_ff <= ST_FULL;
            else                       status_ff <= ST_OK;
            if (ld_active && !long_word && need_new && !full)
               used_ff <= used_ff + 1'b1;
            if (end_ff) begin
               cursor_ff <= '0;
               length_ff <= '0;
               fail_ff   <= ST_OK;
            end else if (ld_active) begin
               if (long_word) begin
                  fail_ff <= ST_TOO_LONG;
               end else if (need_new && full) begin
                  fail_ff <= ST_FULL;
               end else begin
                  cursor_ff <= cand;
                  length_ff <= length_ff + 1'b1;
               end
            end
         end
         if (cmd.q_push) begin
            head_ff <= (head_ff == HIST_W'(MAX_WORD_LEN - 1)) ? '0 : head_ff + 1'b1;
            if (fill_ff < LEN_W'(MAX_WORD_LEN)) fill_ff <= fill_ff + 1'b1;
            pos_ff    <= head_ff;
            node_ff   <= '0;
            idx_ff    <= '0;
            done_ff   <= 1'b0;
            match_ff  <= 1'b0;
            status_ff <= ST_OK;
         end
         if (cmd.q_read && (idx_ff >= fill_ff || rd_hist_ff >= LETTER_W'(ALPHABET_SIZE)))
            done_ff <= 1'b1;
         if (cmd.q_step && !done_ff) begin
            if (rd_link_ff == '0) begin
               done_ff <= 1'b1;
            end else if (rd_mark_ff) begin
               done_ff  <= 1'b1;
               match_ff <= 1'b1;
            end else begin
               node_ff <= rd_link_ff;
               idx_ff  <= idx_ff + 1'b1;
               pos_ff  <= (pos_ff == '0) ? HIST_W'(MAX_WORD_LEN - 1) : pos_ff - 1'b1;
            end
         end
      end
   end

   assign res_match  = match_ff;
   assign res_status = status_ff;
endmodule
`default_nettype wire

FILE: sv/stream_suffix_dictionary_match.sv
// ---------------------------------------------------------------------------
// stream_suffix_dictionary_match
// Reversed-trie dictionary with streaming suffix match.
// ---------------------------------------------------------------------------
// Input words on req_: tdata = letter, tuser = command, tlast = word_end;
// command 0 loads one dictionary letter (last letter of the word first),
// command 1 queries one stream letter.
// Every input word yields one rsp_ word: tdata = {status, match}.
// A load reads the node table, waits for the read and commits. A query pushes
// its letter into the history ring and then walks in steps: one per history letter
// examined plus one that finds the walk over, at most MAX_WORD_LEN+1. A step
// reads the history ring, the node table and the end marks in turn.
// The next word can be taken in the same cycle as the result appears.
// After reset the node table is cleared, one entry a cycle, over all
// NODE_CAPACITY*ALPHABET_SIZE entries; req_tready stays low meanwhile.
// The result sits in an output register; while the receiver stalls it is
// held and the block takes no new word once the next result is ready.
// One item is worked on at a time.
// ---------------------------------------------------------------------------
`default_nettype none
`include "stream_suffix_dictionary_match_defines.svh"
module stream_suffix_dictionary_match
   import ssdm_pkg::*;
#(
   parameter int NODE_CAPACITY = NODE_CAPACITY_DEF,
   parameter int MAX_WORD_LEN  = MAX_WORD_LEN_DEF,
   parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // letter[4:0], pad
   input  wire logic       req_tuser,   // command
   input  wire logic       req_tlast,   // word_end
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata    // match, status[1:0], pad
);
   cmd_type             cmd;
   sts_type             sts;
   logic                res_match;
   logic [STATUS_W-1:0] res_status;
   logic                out_valid_ff;
   logic [2:0]          out_data_ff;

   ssdm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .out_busy (out_valid_ff && !rsp_tready),
      .sts      (sts),
      .cmd      (cmd)
   );

   ssdm_datapath #(
      .NODE_CAPACITY (NODE_CAPACITY),
      .MAX_WORD_LEN  (MAX_WORD_LEN),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .in_command  (req_tuser),
      .in_letter   (req_tdata[LETTER_W-1:0]),
      .in_word_end (req_tlast),
      .res_match   (res_match),
      .res_status  (res_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) out_data_ff <= {res_status, res_match};
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_data_ff};

   `SSDM_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.out_load, !(out_valid_ff && !rsp_tready))
   `SSDM_ASSERT_IMP(a_query_ok, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[2:1] == ST_OK)
   `SSDM_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready)
endmodule
`default_nettype wire
